// File: rtl/ctd_pkg.sv
// ----------------------------------------------------------------------------
// ctd_pkg
// Shared types and constants of the chunked transfer decoder: the command
// word that travels from the parser to the output engine.
// ----------------------------------------------------------------------------
package ctd_pkg;

	localparam int SPACE_DEPTH_DEF = 16;
	localparam int SIZE_BITS_DEF   = 32;

	// Largest whitespace buffer any build may use; sets the index field width.
	localparam int SPACE_DEPTH_MAX = 256;
	localparam int IDX_W           = $clog2(SPACE_DEPTH_MAX);

	// Entries of the command queue between parser and output engine.
	localparam int CMD_Q_DEPTH = 4;

	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_SP = 8'h20;
	localparam logic [7:0] CH_HT = 8'h09;
	localparam logic [7:0] CH_VT = 8'h0B;
	localparam logic [7:0] CH_FF = 8'h0C;

	typedef enum logic [1:0] {
		OP_EMIT  = 2'd0,	// one result beat from the command fields
		OP_WRITE = 2'd1,	// store data into the whitespace buffer at idx
		OP_FLUSH = 2'd2	// emit buffer entries 0..idx, one beat each
	} ctd_op_t;

	typedef struct packed {
		ctd_op_t          op;
		logic [7:0]       data;
		logic [IDX_W-1:0] idx;
		logic             valid;
		logic             err;
		logic             eom;
	} ctd_cmd_t;

endpackage

// File: rtl/chunked_transfer_decoder.sv
// ----------------------------------------------------------------------------
// chunked_transfer_decoder
// Decodes a chunked-transfer byte stream into payload bytes.
// ----------------------------------------------------------------------------
// A message byte is pushed in per beat; decoded bytes come out one per beat
// on a queue-style result port. For most bytes the parser makes at most one
// command for the output engine and takes the next byte right away. A byte
// that flushes buffered whitespace, releases a held-back CR ahead of another
// data byte, or closes a line on in_last may make two or three commands.
// full then stays high while the extra ones enter the four-entry command
// queue, and longer while that queue is full. A flush of n buffered
// whitespace bytes takes n result beats in the output engine, which reads
// one buffer entry per cycle while the result side does not stall; meanwhile
// the parser keeps going until the command queue fills. Results leave at up
// to one per cycle while pop is held; a buffer write in the queue makes no
// result. The whitespace buffer needs no clearing after reset: only entries
// already written in the current line are ever read.
// ----------------------------------------------------------------------------
module chunked_transfer_decoder #(
	parameter int SPACE_DEPTH = ctd_pkg::SPACE_DEPTH_DEF,
	parameter int SIZE_BITS   = ctd_pkg::SIZE_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic       end_of_message,
	output logic       size_error
);

	// Command path: parser -> queue -> output engine.
	logic              q_wr_en;
	ctd_pkg::ctd_cmd_t q_wr_data;
	logic              q_rd_en;
	ctd_pkg::ctd_cmd_t q_head;
	logic              q_empty;
	logic              q_full;

	// Parse the byte stream and classify each line.
	ctd_front #(
		.SPACE_DEPTH (SPACE_DEPTH),
		.SIZE_BITS   (SIZE_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.in_byte   (in_byte),
		.in_last   (in_last),
		.q_wr_en   (q_wr_en),
		.q_wr_data (q_wr_data),
		.q_full    (q_full)
	);

	// Hold commands so parser and output side stall on their own.
	ctd_cmd_fifo u_cmd_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_wr_en),
		.wr_data (q_wr_data),
		.rd_en   (q_rd_en),
		.rd_data (q_head),
		.q_empty (q_empty),
		.q_full  (q_full)
	);

	// Carry out commands: buffer whitespace, flush it, drive result beats.
	ctd_back #(
		.SPACE_DEPTH (SPACE_DEPTH)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (q_head),
		.q_empty        (q_empty),
		.q_rd_en        (q_rd_en),
		.empty          (empty),
		.pop            (pop),
		.out_byte       (out_byte),
		.byte_valid     (byte_valid),
		.end_of_message (end_of_message),
		.size_error     (size_error)
	);

endmodule

// File: rtl/ctd_cmd_fifo.sv
// ----------------------------------------------------------------------------
// ctd_cmd_fifo
// Short command queue that decouples the parser from the output engine.
// ----------------------------------------------------------------------------
module ctd_cmd_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  ctd_pkg::ctd_cmd_t wr_data,
	input  logic              rd_en,
	output ctd_pkg::ctd_cmd_t rd_data,
	output logic              q_empty,
	output logic              q_full
);

	localparam int DEPTH = ctd_pkg::CMD_Q_DEPTH;
	localparam int PW    = $clog2(DEPTH);
	localparam int CNTW  = $clog2(DEPTH + 1);

	ctd_pkg::ctd_cmd_t entry_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [CNTW-1:0]   count_q;

	assign rd_data = entry_q[rd_ptr_q];
	assign q_empty = (count_q == '0);
	assign q_full  = (count_q == CNTW'(DEPTH));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + CNTW'(1);
				2'b01:   count_q <= count_q - CNTW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (!q_full || rd_en))
		else $error("command queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> !q_empty)
		else $error("command queue read while empty");

endmodule

// File: rtl/ctd_front.sv
// ----------------------------------------------------------------------------
// ctd_front
// Line parser: classifies each input byte and turns it into zero to three
// commands for the output engine. Extra commands wait in two pending slots.
// ----------------------------------------------------------------------------
module ctd_front #(
	parameter int SPACE_DEPTH = ctd_pkg::SPACE_DEPTH_DEF,
	parameter int SIZE_BITS   = ctd_pkg::SIZE_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [7:0]        in_byte,
	input  logic              in_last,
	output logic              q_wr_en,
	output ctd_pkg::ctd_cmd_t q_wr_data,
	input  logic              q_full
);

	localparam int CW    = $clog2(SPACE_DEPTH + 1);
	localparam int IDX_W = ctd_pkg::IDX_W;

	typedef enum logic [7:0] {
		MODE_LINE        = 8'b0000_0001,
		MODE_SIZE        = 8'b0000_0010,
		MODE_SIZE_IGNORE = 8'b0000_0100,
		MODE_DATA        = 8'b0000_1000,
		MODE_CHUNK       = 8'b0001_0000,
		MODE_SKIP        = 8'b0010_0000,
		MODE_DONE        = 8'b0100_0000,
		MODE_DISCARD     = 8'b1000_0000
	} mode_t;

	function automatic ctd_pkg::ctd_cmd_t mk_cmd(input ctd_pkg::ctd_op_t op,
		input logic [7:0] data, input logic [IDX_W-1:0] idx,
		input logic valid, input logic err);
		ctd_pkg::ctd_cmd_t c;
		c.op    = op;
		c.data  = data;
		c.idx   = idx;
		c.valid = valid;
		c.err   = err;
		c.eom   = 1'b0;
		return c;
	endfunction

	mode_t          mode_q, mode_n;
	logic [CW-1:0]  count_q, count_n;
	logic           last_cr_q, last_cr_n;
	logic           held_cr_q, held_cr_n;
	logic [SIZE_BITS-1:0] rem_q, rem_n;
	logic [1:0]     skip_q, skip_n;
	logic           lone_q, lone_n;

	ctd_pkg::ctd_cmd_t pend0_q, pend1_q;
	logic [1:0]        pend_cnt_q;

	ctd_pkg::ctd_cmd_t cmds [3];
	logic [1:0]        ncmd;
	logic              has_res;
	logic              do_data;
	logic              is_hex;
	logic [3:0]        hexv;
	logic              is_sp;
	logic [CW-1:0]     eff_cnt;
	logic              accept;

	assign full   = (pend_cnt_q != 2'd0) || q_full;
	assign accept = push && !full;

	always_comb begin
		is_hex = 1'b1;
		hexv   = 4'd0;
		if (in_byte inside {[8'h30:8'h39]}) begin
			hexv = in_byte[3:0];
		end else if (in_byte inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
			hexv = in_byte[3:0] + 4'd9;
		end else begin
			is_hex = 1'b0;
		end
		is_sp = in_byte inside {ctd_pkg::CH_SP, ctd_pkg::CH_HT, ctd_pkg::CH_VT,
			ctd_pkg::CH_FF, ctd_pkg::CH_CR};
	end

	always_comb begin
		mode_n    = mode_q;
		count_n   = count_q;
		last_cr_n = last_cr_q;
		held_cr_n = held_cr_q;
		rem_n     = rem_q;
		skip_n    = skip_q;
		lone_n    = lone_q;
		do_data   = 1'b0;
		ncmd      = 2'd0;
		has_res   = 1'b0;
		eff_cnt   = '0;
		for (int i = 0; i < 3; i++) begin
			cmds[i] = mk_cmd(ctd_pkg::OP_EMIT, 8'h00, '0, 1'b0, 1'b0);
		end

		case (mode_q)
			MODE_LINE: begin
				if (in_byte == ctd_pkg::CH_LF) begin
					// Whitespace-only line: drop one trailing CR, then close with LF.
					eff_cnt = count_q - (last_cr_q ? CW'(1) : CW'(0));
					if (eff_cnt != '0) begin
						cmds[ncmd] = mk_cmd(ctd_pkg::OP_FLUSH, 8'h00,
							IDX_W'(eff_cnt - CW'(1)), 1'b1, 1'b0);
						ncmd = ncmd + 2'd1;
						cmds[ncmd] = mk_cmd(ctd_pkg::OP_EMIT, ctd_pkg::CH_LF, '0,
							1'b1, 1'b0);
						ncmd = ncmd + 2'd1;
						has_res = 1'b1;
					end
					count_n   = '0;
					last_cr_n = 1'b0;
				end else if (is_sp) begin
					if (count_q < CW'(SPACE_DEPTH)) begin
						cmds[ncmd] = mk_cmd(ctd_pkg::OP_WRITE, in_byte, IDX_W'(count_q),
							1'b0, 1'b0);
						ncmd = ncmd + 2'd1;
						count_n   = count_q + CW'(1);
						last_cr_n = (in_byte == ctd_pkg::CH_CR);
					end else begin
						// Buffer overflow: flush it and treat the line as data.
						cmds[ncmd] = mk_cmd(ctd_pkg::OP_FLUSH, 8'h00,
							IDX_W'(count_q - CW'(1)), 1'b1, 1'b0);
						ncmd = ncmd + 2'd1;
						has_res   = 1'b1;
						count_n   = '0;
						last_cr_n = 1'b0;
						held_cr_n = 1'b0;
						mode_n    = MODE_DATA;
						do_data   = 1'b1;
					end
				end else if (is_hex) begin
					count_n   = '0;
					last_cr_n = 1'b0;
					rem_n     = SIZE_BITS'(hexv);
					lone_n    = (hexv == 4'd0);
					mode_n    = MODE_SIZE;
				end else begin
					if (count_q != '0) begin
						cmds[ncmd] = mk_cmd(ctd_pkg::OP_FLUSH, 8'h00,
							IDX_W'(count_q - CW'(1)), 1'b1, 1'b0);
						ncmd = ncmd + 2'd1;
						has_res = 1'b1;
					end
					count_n   = '0;
					last_cr_n = 1'b0;
					held_cr_n = 1'b0;
					mode_n    = MODE_DATA;
					do_data   = 1'b1;
				end
			end
			MODE_SIZE: begin
				if (in_byte == ctd_pkg::CH_LF) begin
					lone_n = 1'b0;
					mode_n = (rem_q == '0) ? MODE_DONE : MODE_CHUNK;
				end else if (is_hex) begin
					if (rem_q[SIZE_BITS-1 -: 4] != 4'd0) begin
						cmds[ncmd] = mk_cmd(ctd_pkg::OP_EMIT, 8'h00, '0, 1'b0, 1'b1);
						ncmd = ncmd + 2'd1;
						has_res = 1'b1;
						rem_n   = '0;
						lone_n  = 1'b0;
						mode_n  = MODE_DISCARD;
					end else begin
						rem_n  = {rem_q[SIZE_BITS-5:0], hexv};
						lone_n = 1'b0;
					end
				end else if ((in_byte == 8'h78 || in_byte == 8'h58) && lone_q) begin
					lone_n = 1'b0;
				end else begin
					mode_n = MODE_SIZE_IGNORE;
				end
			end
			MODE_SIZE_IGNORE: begin
				if (in_byte == ctd_pkg::CH_LF) begin
					lone_n = 1'b0;
					mode_n = (rem_q == '0) ? MODE_DONE : MODE_CHUNK;
				end
			end
			MODE_DATA: begin
				do_data = 1'b1;
			end
			MODE_CHUNK: begin
				cmds[ncmd] = mk_cmd(ctd_pkg::OP_EMIT, in_byte, '0, 1'b1, 1'b0);
				ncmd = ncmd + 2'd1;
				has_res = 1'b1;
				if (rem_q == SIZE_BITS'(1)) begin
					rem_n  = '0;
					skip_n = 2'd2;
					mode_n = MODE_SKIP;
				end else begin
					rem_n = rem_q - SIZE_BITS'(1);
				end
			end
			MODE_SKIP: begin
				if (skip_q <= 2'd1) begin
					skip_n = 2'd0;
					mode_n = MODE_LINE;
				end else begin
					skip_n = skip_q - 2'd1;
				end
			end
			MODE_DISCARD: begin
				if (in_byte == ctd_pkg::CH_LF) begin
					rem_n  = '0;
					mode_n = MODE_LINE;
				end
			end
			MODE_DONE: begin
			end
			default: begin
				mode_n = MODE_LINE;
			end
		endcase

		// Data line byte: hold one CR back so a CR just before LF is dropped.
		if (do_data) begin
			if (in_byte == ctd_pkg::CH_LF) begin
				cmds[ncmd] = mk_cmd(ctd_pkg::OP_EMIT, ctd_pkg::CH_LF, '0, 1'b1, 1'b0);
				ncmd = ncmd + 2'd1;
				has_res   = 1'b1;
				held_cr_n = 1'b0;
				mode_n    = MODE_LINE;
			end else begin
				if (held_cr_n) begin
					cmds[ncmd] = mk_cmd(ctd_pkg::OP_EMIT, ctd_pkg::CH_CR, '0,
						1'b1, 1'b0);
					ncmd = ncmd + 2'd1;
					has_res = 1'b1;
				end
				if (in_byte == ctd_pkg::CH_CR) begin
					held_cr_n = 1'b1;
				end else begin
					held_cr_n = 1'b0;
					cmds[ncmd] = mk_cmd(ctd_pkg::OP_EMIT, in_byte, '0, 1'b1, 1'b0);
					ncmd = ncmd + 2'd1;
					has_res = 1'b1;
				end
			end
		end

		// Last byte: close an open line, mark the final beat, return to reset.
		if (in_last) begin
			if (mode_n == MODE_DATA) begin
				cmds[ncmd] = mk_cmd(ctd_pkg::OP_EMIT, ctd_pkg::CH_LF, '0, 1'b1, 1'b0);
				ncmd = ncmd + 2'd1;
				has_res = 1'b1;
			end else if (mode_n == MODE_LINE && count_n != '0) begin
				eff_cnt = count_n - (last_cr_n ? CW'(1) : CW'(0));
				if (eff_cnt != '0) begin
					cmds[ncmd] = mk_cmd(ctd_pkg::OP_FLUSH, 8'h00,
						IDX_W'(eff_cnt - CW'(1)), 1'b1, 1'b0);
					ncmd = ncmd + 2'd1;
					cmds[ncmd] = mk_cmd(ctd_pkg::OP_EMIT, ctd_pkg::CH_LF, '0,
						1'b1, 1'b0);
					ncmd = ncmd + 2'd1;
					has_res = 1'b1;
				end
			end
			if (!has_res) begin
				cmds[ncmd] = mk_cmd(ctd_pkg::OP_EMIT, 8'h00, '0, 1'b0, 1'b0);
				ncmd = ncmd + 2'd1;
			end
			cmds[ncmd - 2'd1].eom = 1'b1;
			mode_n    = MODE_LINE;
			count_n   = '0;
			last_cr_n = 1'b0;
			held_cr_n = 1'b0;
			rem_n     = '0;
			skip_n    = 2'd0;
			lone_n    = 1'b0;
		end
	end

	always_comb begin
		if (pend_cnt_q != 2'd0) begin
			q_wr_en   = !q_full;
			q_wr_data = pend0_q;
		end else begin
			q_wr_en   = accept && (ncmd != 2'd0);
			q_wr_data = cmds[0];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pend0_q <= cmds[1];
			pend1_q <= cmds[2];
		end else if (pend_cnt_q != 2'd0 && !q_full) begin
			pend0_q <= pend1_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_LINE;
			count_q    <= '0;
			last_cr_q  <= 1'b0;
			held_cr_q  <= 1'b0;
			rem_q      <= '0;
			skip_q     <= 2'd0;
			lone_q     <= 1'b0;
			pend_cnt_q <= 2'd0;
		end else begin
			if (accept) begin
				mode_q     <= mode_n;
				count_q    <= count_n;
				last_cr_q  <= last_cr_n;
				held_cr_q  <= held_cr_n;
				rem_q      <= rem_n;
				skip_q     <= skip_n;
				lone_q     <= lone_n;
				pend_cnt_q <= (ncmd == 2'd0) ? 2'd0 : ncmd - 2'd1;
			end else if (pend_cnt_q != 2'd0 && !q_full) begin
				pend_cnt_q <= pend_cnt_q - 2'd1;
			end
		end
	end

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_cnt_q != 2'd3)
		else $error("more than two commands pending");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(SPACE_DEPTH))
		else $error("whitespace count beyond buffer depth");

endmodule

// File: rtl/ctd_back.sv
// ----------------------------------------------------------------------------
// ctd_back
// Output engine: carries out queued commands, owns the whitespace buffer and
// the result register.
// ----------------------------------------------------------------------------
module ctd_back #(
	parameter int SPACE_DEPTH = ctd_pkg::SPACE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ctd_pkg::ctd_cmd_t head,
	input  logic              q_empty,
	output logic              q_rd_en,
	output logic              empty,
	input  logic              pop,
	output logic [7:0]        out_byte,
	output logic              byte_valid,
	output logic              end_of_message,
	output logic              size_error
);

	localparam int IW = $clog2(SPACE_DEPTH);

	logic [7:0]    mem [SPACE_DEPTH];
	logic [7:0]    rd_q;
	logic [IW-1:0] fidx_q;

	logic       out_v_q;
	logic [7:0] byte_q;
	logic       from_mem_q;
	logic       valid_q;
	logic       err_q;
	logic       eom_q;

	logic load;
	logic take;
	logic flush_end;

	assign load = !out_v_q || pop;
	assign flush_end = (fidx_q == head.idx[IW-1:0]);

	always_comb begin
		q_rd_en = 1'b0;
		take    = 1'b0;
		if (!q_empty) begin
			case (head.op)
				ctd_pkg::OP_WRITE: begin
					q_rd_en = 1'b1;
				end
				ctd_pkg::OP_EMIT: begin
					take    = load;
					q_rd_en = load;
				end
				ctd_pkg::OP_FLUSH: begin
					take    = load;
					q_rd_en = load && flush_end;
				end
				default: begin
					q_rd_en = 1'b1;
				end
			endcase
		end
	end

	// Buffer write and registered read of the entry being flushed.
	always_ff @(posedge clk) begin
		if (!q_empty && head.op == ctd_pkg::OP_WRITE) begin
			mem[head.idx[IW-1:0]] <= head.data;
		end
		if (take && head.op == ctd_pkg::OP_FLUSH) begin
			rd_q <= mem[fidx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (head.op == ctd_pkg::OP_FLUSH) begin
				from_mem_q <= 1'b1;
				valid_q    <= 1'b1;
				err_q      <= 1'b0;
				eom_q      <= head.eom && flush_end;
			end else begin
				from_mem_q <= 1'b0;
				byte_q     <= head.data;
				valid_q    <= head.valid;
				err_q      <= head.err;
				eom_q      <= head.eom;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			fidx_q  <= '0;
		end else begin
			if (take) begin
				out_v_q <= 1'b1;
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
			if (take && head.op == ctd_pkg::OP_FLUSH) begin
				fidx_q <= flush_end ? '0 : fidx_q + IW'(1);
			end
		end
	end

	assign empty          = !out_v_q;
	assign out_byte       = from_mem_q ? rd_q : byte_q;
	assign byte_valid     = valid_q;
	assign end_of_message = eom_q;
	assign size_error     = err_q;

	a_err_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && size_error) |-> !byte_valid)
		else $error("size error beat carries data");

	a_flush_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(!q_empty && head.op == ctd_pkg::OP_FLUSH) |-> (fidx_q <= head.idx[IW-1:0]))
		else $error("flush index ran past its count");

endmodule

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the chunked transfer decoder: message bytes go in,
// a cycle-free line parser or a typed directed row gives each expected beat,
// and each beat popped from the block is compared field by field against it.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SPACE_DEPTH = ctd_pkg::SPACE_DEPTH_DEF;
	localparam int SIZE_BITS   = ctd_pkg::SIZE_BITS_DEF;

	localparam logic [7:0] CH_CR = ctd_pkg::CH_CR;
	localparam logic [7:0] CH_LF = ctd_pkg::CH_LF;
	localparam logic [7:0] CH_SP = ctd_pkg::CH_SP;
	localparam logic [7:0] CH_HT = ctd_pkg::CH_HT;
	localparam logic [7:0] CH_VT = ctd_pkg::CH_VT;
	localparam logic [7:0] CH_FF = ctd_pkg::CH_FF;

	// One decoded beat as it leaves the block.
	typedef struct packed {
		logic [7:0] data;
		logic       valid;
		logic       eom;
		logic       err;
	} beat_t;

	// Line parser states of the predictor.
	typedef enum logic [2:0] {
		PS_LINE,	// at line start, collecting leading whitespace
		PS_SIZE,	// reading hex digits of a size line
		PS_SIZE_TAIL,	// rest of a size line, ignored up to LF
		PS_TEXT,	// passing a plain data line through
		PS_CHUNK,	// passing raw chunk bytes through
		PS_TRAIL,	// dropping the two bytes after a chunk
		PS_DONE,	// zero-size chunk seen, ignore until last byte
		PS_DISCARD	// size overflowed, drop the rest of the line
	} parse_state_t;

	// How a directed row gets its expected beats.
	typedef enum logic [1:0] {
		CHK_MODEL,	// from the predictor
		CHK_ONE,	// exactly the typed beat
		CHK_NONE	// no beat at all
	} row_check_t;

	typedef struct packed {
		logic [7:0] b;
		logic       last;
		row_check_t how;
		beat_t      beat;
	} row_t;

	logic       clk;
	logic       arst_n;
	logic       push;
	logic       full;
	logic [7:0] in_byte;
	logic       in_last;
	logic       empty;
	logic       pop;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       end_of_message;
	logic       size_error;

	chunked_transfer_decoder #(
		.SPACE_DEPTH(SPACE_DEPTH),
		.SIZE_BITS  (SIZE_BITS)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.in_byte       (in_byte),
		.in_last       (in_last),
		.empty         (empty),
		.pop           (pop),
		.out_byte      (out_byte),
		.byte_valid    (byte_valid),
		.end_of_message(end_of_message),
		.size_error    (size_error)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor state: a private copy of the parser.
	// ------------------------------------------------------------------
	parse_state_t ps;
	logic [7:0]   sp_buf [SPACE_DEPTH];
	int           sp_cnt;
	bit           cr_held;
	logic [63:0]  chunk_left;
	int           skip_cnt;
	bit           zero_lead;

	beat_t        byte_beats [$];	// beats caused by the byte just decoded
	beat_t        payload_due [$];	// beats still owed by the block
	logic [7:0]   msg [$];		// message under construction

	bit idle_on;
	int errors;
	int bytes_sent;
	int beats_seen;
	int msgs_sent;
	int err_beats;
	int eom_beats;

	// Directed opener. Typed beats only where the answer is obvious.
	row_t plan [0:24] = '{
		'{"X",   1'b0, CHK_ONE,   '{"X",   1'b1, 1'b0, 1'b0}},	// plain text byte
		'{CH_CR, 1'b0, CHK_NONE,  '{8'h00, 1'b0, 1'b0, 1'b0}},	// CR held back
		'{CH_LF, 1'b0, CHK_ONE,   '{CH_LF, 1'b1, 1'b0, 1'b0}},	// CR dropped, LF out
		'{CH_LF, 1'b0, CHK_NONE,  '{8'h00, 1'b0, 1'b0, 1'b0}},	// blank line
		'{"+",   1'b1, CHK_MODEL, '{8'h00, 1'b0, 1'b0, 1'b0}},	// sign is data; last closes
		'{"1",   1'b0, CHK_NONE,  '{8'h00, 1'b0, 1'b0, 1'b0}},	// size line of one
		'{CH_LF, 1'b0, CHK_NONE,  '{8'h00, 1'b0, 1'b0, 1'b0}},
		'{8'hFF, 1'b0, CHK_ONE,   '{8'hFF, 1'b1, 1'b0, 1'b0}},	// raw chunk byte, top value
		'{CH_CR, 1'b0, CHK_NONE,  '{8'h00, 1'b0, 1'b0, 1'b0}},	// two trailing bytes dropped
		'{CH_LF, 1'b0, CHK_NONE,  '{8'h00, 1'b0, 1'b0, 1'b0}},
		'{"0",   1'b0, CHK_NONE,  '{8'h00, 1'b0, 1'b0, 1'b0}},	// 0x with no digits: size 0
		'{"x",   1'b0, CHK_NONE,  '{8'h00, 1'b0, 1'b0, 1'b0}},
		'{CH_LF, 1'b0, CHK_NONE,  '{8'h00, 1'b0, 1'b0, 1'b0}},
		'{8'h00, 1'b1, CHK_ONE,   '{8'h00, 1'b0, 1'b1, 1'b0}},	// bare end marker
		'{"F",   1'b0, CHK_NONE,  '{8'h00, 1'b0, 1'b0, 1'b0}},	// eight F fill 32 bits
		'{"F",   1'b0, CHK_NONE,  '{8'h00, 1'b0, 1'b0, 1'b0}},
		'{"F",   1'b0, CHK_NONE,  '{8'h00, 1'b0, 1'b0, 1'b0}},
		'{"F",   1'b0, CHK_NONE,  '{8'h00, 1'b0, 1'b0, 1'b0}},
		'{"F",   1'b0, CHK_NONE,  '{8'h00, 1'b0, 1'b0, 1'b0}},
		'{"F",   1'b0, CHK_NONE,  '{8'h00, 1'b0, 1'b0, 1'b0}},
		'{"F",   1'b0, CHK_NONE,  '{8'h00, 1'b0, 1'b0, 1'b0}},
		'{"F",   1'b0, CHK_NONE,  '{8'h00, 1'b0, 1'b0, 1'b0}},
		'{"F",   1'b0, CHK_ONE,   '{8'h00, 1'b0, 1'b0, 1'b1}},	// ninth digit overflows
		'{CH_LF, 1'b0, CHK_NONE,  '{8'h00, 1'b0, 1'b0, 1'b0}},	// end of discarded line
		'{8'h7F, 1'b1, CHK_MODEL, '{8'h00, 1'b0, 1'b0, 1'b0}}	// data line cut by last
	};

	// ------------------------------------------------------------------
	// Predictor helpers
	// ------------------------------------------------------------------
	function automatic int hex_val(input logic [7:0] b);
		if (b >= "0" && b <= "9") return int'(b - "0");
		if (b >= "a" && b <= "f") return int'(b - "a") + 10;
		if (b >= "A" && b <= "F") return int'(b - "A") + 10;
		return -1;
	endfunction

	function automatic bit is_ws(input logic [7:0] b);
		return b == CH_SP || b == CH_HT || b == CH_VT || b == CH_FF || b == CH_CR;
	endfunction

	function automatic void emit(input logic [7:0] d, input logic v, input logic e);
		beat_t bt;
		bt = '{d, v, 1'b0, e};
		byte_beats.push_back(bt);
	endfunction

	function automatic void clear_parser();
		ps         = PS_LINE;
		sp_cnt     = 0;
		cr_held    = 1'b0;
		chunk_left = '0;
		skip_cnt   = 0;
		zero_lead  = 1'b0;
	endfunction

	function automatic void flush_spaces();
		for (int i = 0; i < sp_cnt; i++)
			emit(sp_buf[i], 1'b1, 1'b0);
		sp_cnt = 0;
	endfunction

	// Whitespace-only line: drop one trailing CR, append LF if anything is left.
	function automatic void close_space_line();
		int n;
		n = sp_cnt;
		if (n > 0 && sp_buf[n-1] == CH_CR)
			n--;
		if (n > 0) begin
			for (int i = 0; i < n; i++)
				emit(sp_buf[i], 1'b1, 1'b0);
			emit(CH_LF, 1'b1, 1'b0);
		end
		sp_cnt = 0;
	endfunction

	// Data line byte: hold a CR until we know whether LF follows.
	function automatic void text_char(input logic [7:0] b);
		if (b == CH_LF) begin
			emit(CH_LF, 1'b1, 1'b0);
			cr_held = 1'b0;
			ps      = PS_LINE;
		end else if (b == CH_CR) begin
			if (cr_held)
				emit(CH_CR, 1'b1, 1'b0);
			cr_held = 1'b1;
		end else begin
			if (cr_held)
				emit(CH_CR, 1'b1, 1'b0);
			cr_held = 1'b0;
			emit(b, 1'b1, 1'b0);
		end
	endfunction

	function automatic void close_size_line();
		zero_lead = 1'b0;
		ps = (chunk_left == 0) ? PS_DONE : PS_CHUNK;
	endfunction

	// Decode one accepted byte into byte_beats.
	function automatic void decode_byte(input logic [7:0] b, input logic last);
		int v;
		v = hex_val(b);
		byte_beats.delete();
		case (ps)
			PS_LINE: begin
				if (b == CH_LF) begin
					close_space_line();
				end else if (is_ws(b) && sp_cnt < SPACE_DEPTH) begin
					sp_buf[sp_cnt] = b;
					sp_cnt++;
				end else if (!is_ws(b) && v >= 0) begin
					sp_cnt     = 0;
					chunk_left = 64'(v);
					zero_lead  = (v == 0);
					ps         = PS_SIZE;
				end else begin
					// full whitespace buffer or a non-hex byte: line is data
					flush_spaces();
					cr_held = 1'b0;
					ps      = PS_TEXT;
					text_char(b);
				end
			end
			PS_SIZE: begin
				if (b == CH_LF) begin
					close_size_line();
				end else if (v >= 0) begin
					if ((chunk_left >> (SIZE_BITS - 4)) != 0) begin
						emit(8'h00, 1'b0, 1'b1);
						chunk_left = '0;
						zero_lead  = 1'b0;
						ps         = PS_DISCARD;
					end else begin
						chunk_left = (chunk_left << 4) | 64'(v);
						zero_lead  = 1'b0;
					end
				end else if ((b == "x" || b == "X") && zero_lead) begin
					zero_lead = 1'b0;
				end else begin
					ps = PS_SIZE_TAIL;
				end
			end
			PS_SIZE_TAIL: begin
				if (b == CH_LF)
					close_size_line();
			end
			PS_TEXT: text_char(b);
			PS_CHUNK: begin
				emit(b, 1'b1, 1'b0);
				if (chunk_left > 0)
					chunk_left--;
				if (chunk_left == 0) begin
					skip_cnt = 2;
					ps       = PS_TRAIL;
				end
			end
			PS_TRAIL: begin
				if (skip_cnt > 0)
					skip_cnt--;
				if (skip_cnt == 0)
					ps = PS_LINE;
			end
			PS_DISCARD: begin
				if (b == CH_LF) begin
					chunk_left = '0;
					ps         = PS_LINE;
				end
			end
			default: ;
		endcase

		if (last) begin
			// finish an open data line or buffered whitespace, mark the end
			if (ps == PS_TEXT) begin
				cr_held = 1'b0;
				emit(CH_LF, 1'b1, 1'b0);
			end else if (ps == PS_LINE && sp_cnt > 0) begin
				close_space_line();
			end
			if (byte_beats.size() == 0)
				emit(8'h00, 1'b0, 1'b0);
			byte_beats[byte_beats.size()-1].eom = 1'b1;
			clear_parser();
		end
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 10)
			return 8'("0") + 8'(n);
		return ($urandom_range(0, 1) ? 8'("a") : 8'("A")) + 8'(n) - 8'd10;
	endfunction

	function automatic void add_hex(input logic [31:0] val);
		int top;
		top = 7;
		while (top > 0 && val[top*4 +: 4] == 4'h0)
			top--;
		for (int i = top; i >= 0; i--)
			msg.push_back(hex_char(val[i*4 +: 4]));
	endfunction

	function automatic logic [7:0] rand_ws();
		case ($urandom_range(0, 4))
			0: return CH_SP;
			1: return CH_HT;
			2: return CH_VT;
			3: return CH_FF;
			default: return CH_CR;
		endcase
	endfunction

	// Build a random message, mostly well-formed chunks and lines with
	// some noise, broken size lines and truncation mixed in.
	task automatic compose_message();
		int          kind;
		int          n;
		logic [31:0] size;
		logic [7:0]  c;
		msg.delete();
		repeat ($urandom_range(1, 4)) begin
			kind = $urandom_range(0, 99);
			if (kind < 45) begin
				// chunk: optional indent, optional 0x or leading zero, extension
				repeat ($urandom_range(0, 2))
					msg.push_back($urandom_range(0, 1) ? CH_SP : CH_HT);
				size = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20)
				                                   : $urandom_range(1, 6);
				case ($urandom_range(0, 3))
					0: begin
						msg.push_back("0");
						msg.push_back($urandom_range(0, 1) ? 8'("x") : 8'("X"));
					end
					1: msg.push_back("0");
					default: ;
				endcase
				add_hex(size);
				if ($urandom_range(0, 3) == 0) begin
					msg.push_back(";");
					msg.push_back("e");
					msg.push_back("=");
					msg.push_back(8'($urandom));
				end
				msg.push_back(CH_CR);
				msg.push_back(CH_LF);
				repeat (size)
					msg.push_back(8'($urandom));
				msg.push_back(CH_CR);
				msg.push_back(CH_LF);
			end else if (kind < 60) begin
				// text line: starts with a byte that is neither hex, space nor LF
				do c = 8'($urandom);
				while (hex_val(c) >= 0 || is_ws(c) || c == CH_LF);
				msg.push_back(c);
				repeat ($urandom_range(0, 5)) begin
					do c = 8'($urandom);
					while (c == CH_LF);
					msg.push_back(c);
				end
				if ($urandom_range(0, 1))
					msg.push_back(CH_CR);
				msg.push_back(CH_LF);
			end else if (kind < 72) begin
				// whitespace line, sometimes past the buffer depth
				n = ($urandom_range(0, 2) == 0) ? $urandom_range(SPACE_DEPTH, SPACE_DEPTH + 4)
				                                : $urandom_range(1, 6);
				repeat (n)
					msg.push_back(rand_ws());
				if ($urandom_range(0, 2) == 0)
					msg.push_back("q");
				msg.push_back(CH_LF);
			end else if (kind < 80) begin
				// blank line
				if ($urandom_range(0, 1))
					msg.push_back(CH_CR);
				msg.push_back(CH_LF);
			end else if (kind < 88) begin
				// size line too wide for the counter
				msg.push_back(hex_char(4'($urandom_range(1, 15))));
				repeat ($urandom_range(8, 9))
					msg.push_back(hex_char(4'($urandom)));
				msg.push_back(CH_CR);
				msg.push_back(CH_LF);
			end else begin
				// noise
				repeat ($urandom_range(1, 4))
					msg.push_back(8'($urandom));
			end
		end
		// close with a zero chunk and empty trailer, or cut the tail off
		if ($urandom_range(0, 3) != 0) begin
			msg.push_back("0");
			msg.push_back(CH_CR);
			msg.push_back(CH_LF);
			msg.push_back(CH_CR);
			msg.push_back(CH_LF);
		end else begin
			repeat ($urandom_range(0, 3))
				if (msg.size() > 1)
					msg.delete(msg.size() - 1);
		end
	endtask

	// Offer one byte, wait for the beat, then decode it.
	task automatic send_byte(input logic [7:0] b, input logic last);
		@(negedge clk);
		if (idle_on && $urandom_range(0, 99) < 20) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 2))
				@(negedge clk);
		end
		push    <= 1'b1;
		in_byte <= b;
		in_last <= last;
		do @(posedge clk);
		while (full);
		bytes_sent++;
		decode_byte(b, last);
	endtask

	task automatic drain();
		@(negedge clk);
		push <= 1'b0;
		while (payload_due.size() != 0)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Result side: stall pop at random, check every beat taken.
	// ------------------------------------------------------------------
	always @(negedge clk)
		pop <= !idle_on || ($urandom_range(0, 99) >= 20);

	always @(posedge clk) begin
		beat_t want;
		if (arst_n && pop && !empty) begin
			beats_seen++;
			if (size_error)
				err_beats++;
			if (end_of_message)
				eom_beats++;
			if (payload_due.size() == 0) begin
				$error("unexpected beat: out_byte %h valid %b eom %b err %b",
				       out_byte, byte_valid, end_of_message, size_error);
				errors++;
			end else begin
				want = payload_due.pop_front();
				if (out_byte !== want.data) begin
					$error("out_byte: expected %h, got %h", want.data, out_byte);
					errors++;
				end
				if (byte_valid !== want.valid) begin
					$error("byte_valid: expected %b, got %b", want.valid, byte_valid);
					errors++;
				end
				if (end_of_message !== want.eom) begin
					$error("end_of_message: expected %b, got %b", want.eom, end_of_message);
					errors++;
				end
				if (size_error !== want.err) begin
					$error("size_error: expected %b, got %b", want.err, size_error);
					errors++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		clk        = 1'b0;
		arst_n     = 1'b0;
		push       = 1'b0;
		in_byte    = 8'h00;
		in_last    = 1'b0;
		pop        = 1'b0;
		idle_on    = 1'b1;
		errors     = 0;
		bytes_sent = 0;
		beats_seen = 0;
		msgs_sent  = 0;
		err_beats  = 0;
		eom_beats  = 0;
		clear_parser();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed rows: typed beats where fixed, predictor elsewhere
		foreach (plan[i]) begin
			send_byte(plan[i].b, plan[i].last);
			case (plan[i].how)
				CHK_MODEL: foreach (byte_beats[j]) payload_due.push_back(byte_beats[j]);
				CHK_ONE:   payload_due.push_back(plan[i].beat);
				default:   ;
			endcase
		end

		// hold the sender until every owed beat has come out
		drain();

		// random messages; messages two to four run with no idling on either side
		while (bytes_sent < 140) begin
			compose_message();
			idle_on = (msgs_sent < 1 || msgs_sent > 3);
			foreach (msg[i]) begin
				send_byte(msg[i], i == msg.size() - 1);
				foreach (byte_beats[j])
					payload_due.push_back(byte_beats[j]);
			end
			msgs_sent++;
		end
		idle_on = 1'b1;

		// wait for the tail, then give stray beats time to show
		drain();
		repeat (32) @(posedge clk);

		$display("covered %0d bytes in %0d random messages plus directed rows", bytes_sent,
		         msgs_sent);
		$display("checked %0d beats: %0d message ends, %0d size overflows", beats_seen,
		         eom_beats, err_beats);
		if (errors == 0)
			$display("chunked_transfer_decoder regression: pass");
		else
			$display("chunked_transfer_decoder regression: fail");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#5_000_000;
		$display("chunked_transfer_decoder regression: fail");
		$finish;
	end

endmodule

// File: chunked_transfer_decoder.f
rtl/ctd_pkg.sv
rtl/ctd_cmd_fifo.sv
rtl/ctd_front.sv
rtl/ctd_back.sv
rtl/chunked_transfer_decoder.sv
bench/testbench.sv
